[hw/rtl/psv_pkg.sv]
// Package for the plucked string voice: widths, register indexes, reset values,
// item and control structs, and the rounding helper used by the datapath.
// No dependencies.
package psv_pkg;

	// Storage and sample widths
	localparam int MAX_DELAY_DEF = 4096;
	localparam int SMP_W         = 16;
	localparam int FRAC_W        = 16;
	localparam int COEF_W        = FRAC_W + 1;
	localparam int DINT_W        = 12;
	localparam int BURST_W       = 12;
	localparam int CFG_W         = 17;
	localparam int IDX_W         = 3;

	// Multiplier operand and product widths
	localparam int OPD_W  = SMP_W + 2;
	localparam int PROD_W = 2 * OPD_W;
	localparam int RND_W  = PROD_W - FRAC_W;

	localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1 << FRAC_W);

	// Register indexes
	localparam logic [IDX_W-1:0] REG_DELAY_INT     = 3'd0;
	localparam logic [IDX_W-1:0] REG_DELAY_FRAC    = 3'd1;
	localparam logic [IDX_W-1:0] REG_DAMPING       = 3'd2;
	localparam logic [IDX_W-1:0] REG_LOOP_GAIN     = 3'd3;
	localparam logic [IDX_W-1:0] REG_EXCITER_LEVEL = 3'd4;
	localparam logic [IDX_W-1:0] REG_BURST_LENGTH  = 3'd5;
	localparam logic [IDX_W-1:0] REG_LAST          = REG_BURST_LENGTH;

	// Register reset values
	localparam logic [DINT_W-1:0]  RST_DELAY_INT     = 12'd100;
	localparam logic [FRAC_W-1:0]  RST_DELAY_FRAC    = 16'd0;
	localparam logic [COEF_W-1:0]  RST_DAMPING       = 17'd32768;
	localparam logic [FRAC_W-1:0]  RST_LOOP_GAIN     = 16'd64880;
	localparam logic [COEF_W-1:0]  RST_EXCITER_LEVEL = 17'd65536;
	localparam logic [BURST_W-1:0] RST_BURST_LENGTH  = 12'd48;

	typedef struct packed {
		logic                    action;
		logic signed [SMP_W-1:0] noise;
	} in_item_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] sample;
		logic                    exciting;
	} out_item_t;

	typedef struct packed {
		logic [DINT_W-1:0]  delay_int;
		logic [FRAC_W-1:0]  delay_frac;
		logic [COEF_W-1:0]  damping;
		logic [FRAC_W-1:0]  loop_gain;
		logic [COEF_W-1:0]  exciter_level;
		logic [BURST_W-1:0] burst_length;
	} cfg_t;

	// Controller to datapath: one step strobe per cycle of the item schedule; commit waits while the output is not free
	typedef struct packed {
		logic start;
		logic step_x1;
		logic step_dif;
		logic step_tap;
		logic step_lpm;
		logic step_lpu;
		logic step_fbm;
		logic commit;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;
	} sts_t;

	// Round a Q.16 product half up to an integer, floor shift
	function automatic logic signed [RND_W-1:0] rnd_q16(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] s;
		s = v + $signed(PROD_W'(1) << (FRAC_W - 1));
		return s[PROD_W-1:FRAC_W];
	endfunction

endpackage

[hw/rtl/psv_ctrl.sv]
// Sequencer for the plucked string voice: walks each item through the read,
// multiply and write-back steps. Depends on psv_pkg.
module psv_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  psv_pkg::sts_t sts,
	output psv_pkg::cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD1  = 3'd1;
	localparam logic [2:0] S_RD2  = 3'd2;
	localparam logic [2:0] S_TAP  = 3'd3;
	localparam logic [2:0] S_LPM  = 3'd4;
	localparam logic [2:0] S_LPU  = 3'd5;
	localparam logic [2:0] S_FBM  = 3'd6;
	localparam logic [2:0] S_WR   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Take an item only between items
	assign in_ready = (state_q == S_IDLE);

	// Decode step strobes
	always_comb begin
		cmd          = '0;
		cmd.start    = in_ready && in_valid;
		cmd.step_x1  = (state_q == S_RD1);
		cmd.step_dif = (state_q == S_RD2);
		cmd.step_tap = (state_q == S_TAP);
		cmd.step_lpm = (state_q == S_LPM);
		cmd.step_lpu = (state_q == S_LPU);
		cmd.step_fbm = (state_q == S_FBM);
		cmd.commit   = (state_q == S_WR) && sts.out_free;
	end

	// Advance through the schedule; hold in write-back while the result is unread
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_RD1;
			end
			S_RD1:   state_d = S_RD2;
			S_RD2:   state_d = S_TAP;
			S_TAP:   state_d = S_LPM;
			S_LPM:   state_d = S_LPU;
			S_LPU:   state_d = S_FBM;
			S_FBM:   state_d = S_WR;
			S_WR: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[hw/rtl/psv_dp.sv]
// Datapath for the plucked string voice: delay memory, shared multiplier,
// interpolation, lowpass, burst counter and output register. Depends on psv_pkg.
module psv_dp #(
	parameter int MAX_DELAY = psv_pkg::MAX_DELAY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  psv_pkg::cfg_t      cfg,
	input  psv_pkg::cmd_t      cmd,
	output psv_pkg::sts_t      sts,
	input  psv_pkg::in_item_t  in_item,
	output psv_pkg::out_item_t out_item,
	output logic               out_valid,
	input  logic               out_ready
);

	localparam int PW = $clog2(MAX_DELAY);
	localparam int KW = (PW + 1 > psv_pkg::DINT_W + 1) ? PW + 1 : psv_pkg::DINT_W + 1;
	localparam int SW = psv_pkg::SMP_W;
	localparam int OW = psv_pkg::OPD_W;
	localparam int RW = psv_pkg::RND_W;
	localparam int PRW = psv_pkg::PROD_W;
	localparam logic signed [RW-1:0] SAT_HI = RW'((1 << (SW - 1)) - 1);
	localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

	logic [SW-1:0] delay_mem [MAX_DELAY];

	logic [PW-1:0]  wp_q;
	logic [PW:0]    fill_q;
	logic [KW-1:0]  dly_raw, dly, maxb, k_rd, wp_ext, ago_ext, burst_ld, burst_cur;
	logic [PW-1:0]  rd_addr;
	logic           rd_ok_q;
	logic signed [SW-1:0] rd_q, x0_q, x1, tap_q, lp_q, nz_q, noise_q, nz_add, fb_sat;
	logic [psv_pkg::BURST_W-1:0] burst_q;
	logic           exc;
	logic [psv_pkg::COEF_W-1:0] damp_cl, lvl_cl;
	logic signed [OW-1:0]  mul_a, mul_b;
	logic signed [PRW-1:0] prod_q, tap_sum, lp_sum;
	logic signed [RW-1:0]  tap_rnd, lp_rnd, prod_rnd, fb_sum;
	psv_pkg::out_item_t    out_q;
	logic                  out_valid_q;

	// Clamp delay and coefficients into their working ranges
	always_comb begin
		dly_raw = KW'(cfg.delay_int);
		if (dly_raw < KW'(2)) begin
			dly = KW'(2);
		end else if (dly_raw > KW'(MAX_DELAY - 2)) begin
			dly = KW'(MAX_DELAY - 2);
		end else begin
			dly = dly_raw;
		end
		maxb    = dly - KW'(1);
		damp_cl = (cfg.damping > psv_pkg::COEF_ONE) ? psv_pkg::COEF_ONE : cfg.damping;
		lvl_cl  = (cfg.exciter_level > psv_pkg::COEF_ONE) ? psv_pkg::COEF_ONE
			: cfg.exciter_level;
	end

	// Burst length for a pluck, and the counter re-clamped to the current delay
	always_comb begin
		burst_ld = KW'(cfg.burst_length);
		if (burst_ld > maxb) burst_ld = maxb;
		if (burst_ld == '0) burst_ld = KW'(1);
		burst_cur = (KW'(burst_q) > maxb) ? maxb : KW'(burst_q);
		exc       = (burst_q != '0);
	end

	// Tap address: newer sample first, older one on the next cycle
	always_comb begin
		k_rd    = cmd.step_x1 ? dly + KW'(1) : dly;
		wp_ext  = KW'(wp_q);
		ago_ext = (wp_ext < k_rd) ? wp_ext + KW'(MAX_DELAY) - k_rd : wp_ext - k_rd;
		rd_addr = ago_ext[PW-1:0];
	end

	// Delay memory: one read port, one write port
	always_ff @(posedge clk) begin
		rd_q <= delay_mem[rd_addr];
		if (cmd.commit) delay_mem[wp_q] <= fb_sat;
	end

	// Entries not yet written since reset read as zero
	assign x1 = rd_ok_q ? rd_q : '0;

	// Select multiplier operands for the current step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (cmd.step_dif) begin
			mul_a = OW'(x1) - OW'(x0_q);
			mul_b = $signed(OW'(cfg.delay_frac));
		end else if (cmd.step_tap) begin
			mul_a = OW'(noise_q);
			mul_b = $signed(OW'(lvl_cl));
		end else if (cmd.step_lpm) begin
			mul_a = OW'(lp_q) - OW'(tap_q);
			mul_b = $signed(OW'(damp_cl));
		end else if (cmd.step_fbm) begin
			mul_a = OW'(lp_q);
			mul_b = $signed(OW'(cfg.loop_gain));
		end
	end

	// Interpolation, lowpass and feedback sums
	always_comb begin
		tap_sum  = (PRW'(x0_q) <<< psv_pkg::FRAC_W) + prod_q;
		lp_sum   = (PRW'(tap_q) <<< psv_pkg::FRAC_W) + prod_q;
		tap_rnd  = psv_pkg::rnd_q16(tap_sum);
		lp_rnd   = psv_pkg::rnd_q16(lp_sum);
		prod_rnd = psv_pkg::rnd_q16(prod_q);
		nz_add   = exc ? nz_q : '0;
		fb_sum   = prod_rnd + RW'(nz_add);
		if (fb_sum > SAT_HI) begin
			fb_sat = SAT_HI[SW-1:0];
		end else if (fb_sum < SAT_LO) begin
			fb_sat = SAT_LO[SW-1:0];
		end else begin
			fb_sat = fb_sum[SW-1:0];
		end
	end

	// Working registers of one item
	always_ff @(posedge clk) begin
		if (cmd.start) noise_q <= in_item.noise;
		if (cmd.step_x1) x0_q <= rd_ok_q ? rd_q : '0;
		if (cmd.step_dif || cmd.step_tap || cmd.step_lpm || cmd.step_fbm) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.step_tap) tap_q <= tap_rnd[SW-1:0];
		if (cmd.step_lpm) nz_q <= prod_rnd[SW-1:0];
		if (cmd.commit) begin
			out_q.sample   <= tap_q;
			out_q.exciting <= exc;
		end
	end

	// Loop state, fill count and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			fill_q      <= '0;
			lp_q        <= '0;
			burst_q     <= '0;
			rd_ok_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_ok_q <= (KW'(fill_q) >= k_rd);
			if (cmd.start && in_item.action) burst_q <= burst_ld[psv_pkg::BURST_W-1:0];
			if (cmd.step_lpu) lp_q <= lp_rnd[SW-1:0];
			if (cmd.commit) begin
				wp_q <= (wp_q == PW'(MAX_DELAY - 1)) ? '0 : wp_q + PW'(1);
				if (fill_q != (PW + 1)'(MAX_DELAY)) fill_q <= fill_q + (PW + 1)'(1);
				if (exc) begin
					burst_q <= burst_cur[psv_pkg::BURST_W-1:0] - psv_pkg::BURST_W'(1);
				end
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_item     = out_q;
	assign out_valid    = out_valid_q;
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

[hw/rtl/plucked_string_voice.sv]
// Top level of the plucked string voice: configuration registers, sequencer
// and datapath. Depends on psv_pkg, psv_ctrl and psv_dp.
//
// One input item is one sample tick (with an optional pluck) and gives one
// result item. An item is written back in S_WR after the states S_RD1, S_RD2,
// S_TAP, S_LPM, S_LPU and S_FBM, and the next item is taken only once the
// sequencer is back in S_IDLE, so items never overlap: the two taps go
// through the single read port of the delay memory, then four products through
// one shared 18x18 multiplier, each registered before its sum is rounded, plus
// the lowpass update and the write-back. The result sits in an output
// register; the next item is taken as soon as write-back is done, and
// write-back waits only if the previous result has not yet been taken.
// The delay memory holds MAX_DELAY samples and needs no clearing pass after
// reset: a fill count makes entries not yet written read as zero, so items
// are accepted straight after reset. Configuration writes take
// effect at once and should only be made between items.
module plucked_string_voice #(
	parameter int MAX_DELAY = psv_pkg::MAX_DELAY_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  psv_pkg::in_item_t           in_item,
	output logic                        out_valid,
	input  logic                        out_ready,
	output psv_pkg::out_item_t          out_item,
	input  logic                        cfg_write,
	input  logic [psv_pkg::IDX_W-1:0]   cfg_index,
	input  logic [psv_pkg::CFG_W-1:0]   cfg_data
);

	psv_pkg::cfg_t cfg_q;
	psv_pkg::cmd_t cmd;
	psv_pkg::sts_t sts;

	// Configuration registers; writes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay_int     <= psv_pkg::RST_DELAY_INT;
			cfg_q.delay_frac    <= psv_pkg::RST_DELAY_FRAC;
			cfg_q.damping       <= psv_pkg::RST_DAMPING;
			cfg_q.loop_gain     <= psv_pkg::RST_LOOP_GAIN;
			cfg_q.exciter_level <= psv_pkg::RST_EXCITER_LEVEL;
			cfg_q.burst_length  <= psv_pkg::RST_BURST_LENGTH;
		end else if (cfg_write) begin
			case (cfg_index)
				psv_pkg::REG_DELAY_INT:     cfg_q.delay_int     <= cfg_data[psv_pkg::DINT_W-1:0];
				psv_pkg::REG_DELAY_FRAC:    cfg_q.delay_frac    <= cfg_data[psv_pkg::FRAC_W-1:0];
				psv_pkg::REG_DAMPING:       cfg_q.damping       <= cfg_data[psv_pkg::COEF_W-1:0];
				psv_pkg::REG_LOOP_GAIN:     cfg_q.loop_gain     <= cfg_data[psv_pkg::FRAC_W-1:0];
				psv_pkg::REG_EXCITER_LEVEL: cfg_q.exciter_level <= cfg_data[psv_pkg::COEF_W-1:0];
				psv_pkg::REG_BURST_LENGTH:  cfg_q.burst_length  <= cfg_data[psv_pkg::BURST_W-1:0];
				default: ;
			endcase
		end
	end

	psv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	psv_dp #(
		.MAX_DELAY (MAX_DELAY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.sts       (sts),
		.in_item   (in_item),
		.out_item  (out_item),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

`ifndef ASSERT_OFF
	// Only one item in flight: no second item right after an accepted one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("item accepted while another is in flight");

	// Write-back never overwrites a result still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid || out_ready))
		else $error("write-back over an untaken result");

	// Write-back always presents a result
	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid)
		else $error("write-back without a result");

	// Writes beyond the register list leave the configuration untouched
	a_cfg_ignore: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_write && (cfg_index > psv_pkg::REG_LAST)) |=> $stable(cfg_q))
		else $error("configuration changed by a write beyond the list");
`endif

endmodule

[test/string_loop_checker_pkg.sv]
// Expected-result tracker for the plucked string voice testbench: a bit-exact
// model of the string loop and the queue of tap samples it predicts.
// Depends on psv_pkg.
package string_loop_checker_pkg;
	import psv_pkg::*;

	localparam longint SAMPLE_HI = (longint'(1) << (SMP_W - 1)) - 1;
	localparam longint SAMPLE_LO = -SAMPLE_HI - 1;
	localparam longint UNITY     = longint'(1) << FRAC_W;
	localparam longint HALF_LSB  = longint'(1) << (FRAC_W - 1);

	class string_loop_checker;
		logic signed [SMP_W-1:0] line_mem [MAX_DELAY_DEF];
		int unsigned             wr_ptr;
		logic signed [SMP_W-1:0] lp_q;
		int unsigned             burst_left;
		cfg_t                    regs;
		out_item_t               due_samples [$];
		int                      mismatches;

		function new();
			foreach (line_mem[i]) line_mem[i] = '0;
			wr_ptr              = 0;
			lp_q                = '0;
			burst_left          = 0;
			mismatches          = 0;
			regs.delay_int      = RST_DELAY_INT;
			regs.delay_frac     = RST_DELAY_FRAC;
			regs.damping        = RST_DAMPING;
			regs.loop_gain      = RST_LOOP_GAIN;
			regs.exciter_level  = RST_EXCITER_LEVEL;
			regs.burst_length   = RST_BURST_LENGTH;
		endfunction

		// Q.16 product to integer: add half an LSB, then floor shift
		function longint round_q16(longint v);
			return (v + HALF_LSB) >>> FRAC_W;
		endfunction

		// Keep only the register's own bits; drop writes past the last index
		function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_DELAY_INT:     regs.delay_int     = data[DINT_W-1:0];
				REG_DELAY_FRAC:    regs.delay_frac    = data[FRAC_W-1:0];
				REG_DAMPING:       regs.damping       = data[COEF_W-1:0];
				REG_LOOP_GAIN:     regs.loop_gain     = data[FRAC_W-1:0];
				REG_EXCITER_LEVEL: regs.exciter_level = data[COEF_W-1:0];
				REG_BURST_LENGTH:  regs.burst_length  = data[BURST_W-1:0];
				default: ;
			endcase
		endfunction

		// Advance the string by one tick and queue the tap it produces
		function void note_tick(in_item_t it);
			int unsigned dly;
			int unsigned maxb;
			int unsigned blen;
			int unsigned p0;
			int unsigned p1;
			longint      frac;
			longint      damp;
			longint      gain;
			longint      lvl;
			longint      x0;
			longint      x1;
			longint      tap;
			longint      fb;
			out_item_t   want;

			// Clamp the delay and the coefficients
			dly = regs.delay_int;
			if (dly < 2) dly = 2;
			if (dly > MAX_DELAY_DEF - 2) dly = MAX_DELAY_DEF - 2;
			maxb = dly - 1;
			frac = regs.delay_frac;
			damp = (regs.damping > COEF_ONE) ? UNITY : longint'(regs.damping);
			gain = regs.loop_gain;
			lvl  = (regs.exciter_level > COEF_ONE) ? UNITY : longint'(regs.exciter_level);

			// A pluck reloads the burst counter
			if (it.action) begin
				blen = regs.burst_length;
				if (blen > maxb) blen = maxb;
				if (blen < 1) blen = 1;
				burst_left = blen;
			end

			// Interpolated tap, lowpass, loop gain
			p0  = (wr_ptr + MAX_DELAY_DEF - dly) % MAX_DELAY_DEF;
			p1  = (wr_ptr + MAX_DELAY_DEF - dly - 1) % MAX_DELAY_DEF;
			x0  = line_mem[p0];
			x1  = line_mem[p1];
			tap = round_q16(x0 * (UNITY - frac) + x1 * frac);
			lp_q = SMP_W'(round_q16((UNITY - damp) * tap + damp * lp_q));
			fb   = round_q16(lp_q * gain);

			// Inject noise while the burst lasts
			want.exciting = 1'b0;
			if (burst_left > 0) begin
				if (burst_left > maxb) burst_left = maxb;
				fb += round_q16(longint'($signed(it.noise)) * lvl);
				burst_left--;
				want.exciting = 1'b1;
			end

			// Saturate and write back
			if (fb > SAMPLE_HI) fb = SAMPLE_HI;
			else if (fb < SAMPLE_LO) fb = SAMPLE_LO;
			line_mem[wr_ptr] = SMP_W'(fb);
			wr_ptr = (wr_ptr + 1) % MAX_DELAY_DEF;

			want.sample = SMP_W'(tap);
			due_samples.push_back(want);
		endfunction

		// Compare a result with the oldest predicted tap
		function void check_sample(out_item_t got);
			out_item_t want;
			if (due_samples.size() == 0) begin
				$error("result with none due: sample %0d, exciting %0b",
					got.sample, got.exciting);
				mismatches++;
				return;
			end
			want = due_samples.pop_front();
			if (got.sample !== want.sample) begin
				$error("sample: expected %0d, got %0d", want.sample, got.sample);
				mismatches++;
			end
			if (got.exciting !== want.exciting) begin
				$error("exciting: expected %0b, got %0b", want.exciting, got.exciting);
				mismatches++;
			end
		endfunction
	endclass

endpackage

[test/testbench.sv]
// Testbench for plucked_string_voice: directed and random sample ticks under
// several register settings and idling patterns, checked by string_loop_checker.
// Depends on psv_pkg, string_loop_checker_pkg and the block's RTL.
module testbench;
	import psv_pkg::*;
	import string_loop_checker_pkg::*;

	localparam int QUIET_LIMIT   = 4000;
	localparam int SETTLE_CYCLES = 16;
	localparam int ITEMS_PER_SET = 98;
	localparam int PLUCK_PCT     = 4;
	localparam logic signed [SMP_W-1:0] NOISE_TOP    = {1'b0, {(SMP_W-1){1'b1}}};
	localparam logic signed [SMP_W-1:0] NOISE_BOTTOM = {1'b1, {(SMP_W-1){1'b0}}};

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	in_item_t         in_item   = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_item_t        out_item;
	logic             cfg_write = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data  = '0;

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int quiet_cycles  = 0;

	string_loop_checker loop_model = new();

	plucked_string_voice i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stall the result side at random
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Check results, log ticks and register writes, and watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) loop_model.check_sample(out_item);
			if (in_valid && in_ready) loop_model.note_tick(in_item);
			if (cfg_write) loop_model.write_reg(cfg_index, cfg_data);
			if ((out_valid && out_ready) || (in_valid && in_ready) || cfg_write) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("testbench: done, errors");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	function automatic in_item_t tick_of(logic pluck, logic signed [SMP_W-1:0] noise);
		in_item_t it;
		it.action = pluck;
		it.noise  = noise;
		return it;
	endfunction

	// Mostly plain ticks with white noise; extremes now and then
	function automatic in_item_t random_tick();
		logic signed [SMP_W-1:0] n;
		case ($urandom_range(9))
			0:       n = NOISE_TOP;
			1:       n = NOISE_BOTTOM;
			default: n = SMP_W'($urandom);
		endcase
		return tick_of($urandom_range(99) < PLUCK_PCT, n);
	endfunction

	function automatic cfg_t random_setting();
		cfg_t s;
		s.delay_int     = ($urandom_range(9) == 0) ? DINT_W'($urandom)
			: DINT_W'($urandom_range(2, 40));
		s.delay_frac    = FRAC_W'($urandom);
		s.damping       = ($urandom_range(7) == 0) ? COEF_W'($urandom)
			: COEF_W'($urandom_range(0, COEF_ONE));
		s.loop_gain     = ($urandom_range(1) == 0) ? FRAC_W'($urandom_range(60000, 65535))
			: FRAC_W'($urandom);
		s.exciter_level = ($urandom_range(7) == 0) ? COEF_W'($urandom)
			: COEF_W'($urandom_range(0, COEF_ONE));
		s.burst_length  = ($urandom_range(3) == 0) ? BURST_W'($urandom)
			: BURST_W'($urandom_range(0, 60));
		return s;
	endfunction

	// Fill the bits above a narrow register at random half of the time
	function automatic logic [CFG_W-1:0] pad_junk(logic [CFG_W-1:0] v, int w);
		if (w >= CFG_W || $urandom_range(1) == 0) return v;
		return v | (CFG_W'($urandom) << w);
	endfunction

	task automatic set_idling(idle_mode_e mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct = 0;
				stall_pct     = 0;
			end
			IDLE_SENDER: begin
				send_idle_pct = 73;
				stall_pct     = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct = 0;
				stall_pct     = 73;
			end
			default: begin
				send_idle_pct = 28;
				stall_pct     = 28;
			end
		endcase
	endtask

	// Offer one tick after a random gap and hold it until taken
	task automatic send_tick(in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (!(in_valid && in_ready));
		@(negedge clk);
	endtask

	task automatic run_random(int count);
		repeat (count) send_tick(random_tick());
	endtask

	// Drop valid and wait until every due tap has come back
	task automatic settle_voice();
		in_valid <= 1'b0;
		while (loop_model.due_samples.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic put_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
	endtask

	// Write all registers, then poke the unused indexes, which must be ignored
	task automatic load_setting(cfg_t s);
		put_reg(REG_DELAY_INT,     pad_junk(CFG_W'(s.delay_int), DINT_W));
		put_reg(REG_DELAY_FRAC,    pad_junk(CFG_W'(s.delay_frac), FRAC_W));
		put_reg(REG_DAMPING,       pad_junk(CFG_W'(s.damping), COEF_W));
		put_reg(REG_LOOP_GAIN,     pad_junk(CFG_W'(s.loop_gain), FRAC_W));
		put_reg(REG_EXCITER_LEVEL, pad_junk(CFG_W'(s.exciter_level), COEF_W));
		put_reg(REG_BURST_LENGTH,  pad_junk(CFG_W'(s.burst_length), BURST_W));
		put_reg(IDX_W'(REG_LAST + 1), CFG_W'($urandom));
		put_reg(IDX_W'(REG_LAST + 2), CFG_W'($urandom));
		cfg_write <= 1'b0;
	endtask

	initial begin
		cfg_t s;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: pluck against the reset burst length, reload mid-burst
		set_idling(IDLE_NONE);
		send_tick(tick_of(1'b1, NOISE_TOP));
		send_tick(tick_of(1'b0, NOISE_BOTTOM));
		send_tick(tick_of(1'b0, '0));
		send_tick(tick_of(1'b1, 16'sh5555));
		send_tick(tick_of(1'b0, 16'shAAAA));
		send_tick(tick_of(1'b0, -16'sd1));
		run_random(ITEMS_PER_SET);
		settle_voice();

		// Shortest loop, zero burst length, level above one; drive into saturation
		s.delay_int     = '0;
		s.delay_frac    = '1;
		s.damping       = '0;
		s.loop_gain     = '1;
		s.exciter_level = '1;
		s.burst_length  = '0;
		load_setting(s);
		set_idling(IDLE_SENDER);
		send_tick(tick_of(1'b1, NOISE_TOP));
		send_tick(tick_of(1'b0, NOISE_TOP));
		send_tick(tick_of(1'b1, NOISE_TOP));
		send_tick(tick_of(1'b1, NOISE_TOP));
		send_tick(tick_of(1'b1, NOISE_TOP));
		send_tick(tick_of(1'b0, '0));
		send_tick(tick_of(1'b1, NOISE_BOTTOM));
		send_tick(tick_of(1'b1, NOISE_BOTTOM));
		send_tick(tick_of(1'b1, NOISE_BOTTOM));
		send_tick(tick_of(1'b1, NOISE_BOTTOM));
		send_tick(tick_of(1'b0, NOISE_BOTTOM));
		send_tick(tick_of(1'b1, 16'sd1));
		send_tick(tick_of(1'b0, '0));
		send_tick(tick_of(1'b0, '0));
		run_random(ITEMS_PER_SET);
		settle_voice();

		// Longest loop, damping above one, zero gain and level, longest burst
		s.delay_int     = '1;
		s.delay_frac    = '0;
		s.damping       = '1;
		s.loop_gain     = '0;
		s.exciter_level = '0;
		s.burst_length  = '1;
		load_setting(s);
		set_idling(IDLE_RECEIVER);
		run_random(ITEMS_PER_SET);
		settle_voice();

		// Delay below range, half-way interpolation, damping and level at one
		s.delay_int     = DINT_W'(1);
		s.delay_frac    = FRAC_W'(COEF_ONE >> 1);
		s.damping       = COEF_ONE;
		s.loop_gain     = '1;
		s.exciter_level = COEF_ONE;
		s.burst_length  = BURST_W'(1);
		load_setting(s);
		set_idling(IDLE_BOTH);
		run_random(ITEMS_PER_SET);
		settle_voice();

		// Random settings, cycling through the idling patterns
		for (int ph = 0; ph < 5; ph++) begin
			load_setting(random_setting());
			set_idling(idle_mode_e'(ph % 4));
			run_random(ITEMS_PER_SET);
			settle_voice();
		end

		if (loop_model.mismatches == 0 && loop_model.due_samples.size() == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
